// ----- hdl/dtdf_pkg.sv -----
package dtdf_pkg;

  localparam int unsigned WORD_W  = 64;
  localparam int unsigned EXP_W   = 11;
  localparam int unsigned MANT_W  = 52;
  localparam int unsigned IPART_W = MANT_W + 1;
  localparam int unsigned FRAC_W  = MANT_W;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned PROD_W  = FRAC_W + DIGIT_W;
  localparam int unsigned SHIFT_W = 6;
  localparam int unsigned WIDE_W  = IPART_W + FRAC_W;

  localparam logic [EXP_W-1:0] EXP_BIAS = EXP_W'(1023);
  localparam logic [EXP_W-1:0] EXP_MAX  = EXP_W'(1023 + MANT_W);

  typedef enum logic [1:0] {
    KIND_INT   = 2'd0,
    KIND_DIGIT = 2'd1,
    KIND_RANGE = 2'd2
  } kind_e;

  typedef struct packed {
    logic                in_range;
    logic                sign;
    logic [IPART_W-1:0]  ipart;
    logic [FRAC_W-1:0]   frac;
  } unpack_t;

  typedef struct packed {
    logic [DIGIT_W-1:0]  digit;
    logic [FRAC_W-1:0]   frac;
  } step_t;

endpackage

// ----- hdl/dtdf_unpack.sv -----
module dtdf_unpack (
  input  logic [dtdf_pkg::WORD_W-1:0] raw_bits_i,
  output dtdf_pkg::unpack_t           unp_o
);
  import dtdf_pkg::*;

  logic [EXP_W-1:0]   bexp;
  logic [EXP_W-1:0]   exp_ofs;
  logic [SHIFT_W-1:0] shamt;
  logic [WIDE_W-1:0]  wide;

  assign bexp    = raw_bits_i[WORD_W-2 -: EXP_W];
  assign exp_ofs = bexp - EXP_BIAS;
  assign shamt   = exp_ofs[SHIFT_W-1:0];

  // align the binary point to bit FRAC_W
  assign wide = {{(WIDE_W-IPART_W){1'b0}}, 1'b1, raw_bits_i[MANT_W-1:0]} << shamt;

  always_comb begin
    unp_o.in_range = (bexp >= EXP_BIAS) && (bexp <= EXP_MAX);
    unp_o.sign     = raw_bits_i[WORD_W-1];
    unp_o.ipart    = wide[WIDE_W-1:FRAC_W];
    unp_o.frac     = wide[FRAC_W-1:0];
  end

endmodule

// ----- hdl/dtdf_step.sv -----
module dtdf_step (
  input  logic [dtdf_pkg::FRAC_W-1:0] frac_i,
  output dtdf_pkg::step_t             step_o
);
  import dtdf_pkg::*;

  logic [PROD_W-1:0] ext;
  logic [PROD_W-1:0] prod;

  // times ten as x*8 + x*2
  assign ext  = {{DIGIT_W{1'b0}}, frac_i};
  assign prod = (ext << 3) + (ext << 1);

  always_comb begin
    step_o.digit = prod[PROD_W-1:FRAC_W];
    step_o.frac  = prod[FRAC_W-1:0];
  end

endmodule

// ----- hdl/double_to_decimal_fraction_digits_unit.sv -----
// Exact decimal expansion of a binary64 word. Each accepted word gives one
// integer-part word (sign and integer part), then one word per exact decimal
// digit of the binary fraction, last_item_o marking the final one; an unbiased
// exponent outside 0..52 gives a single out-of-range word instead. The
// times-ten unit produces one digit per cycle from the fraction register while
// the output is not stalled, and in_stall_o stays high from acceptance until the
// last word is taken.
module double_to_decimal_fraction_digits_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [dtdf_pkg::WORD_W-1:0]  raw_bits_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   item_kind_o,
  output logic                         sign_bit_o,
  output logic [dtdf_pkg::IPART_W-1:0] integer_part_o,
  output logic [dtdf_pkg::DIGIT_W-1:0] decimal_digit_o,
  output logic                         last_item_o
);
  import dtdf_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_OUT  = 2'b10
  } state_e;

  state_e             state_q, state_d;
  kind_e              kind_q, kind_d;
  logic               sign_q, sign_d;
  logic [IPART_W-1:0] ipart_q, ipart_d;
  logic [DIGIT_W-1:0] digit_q, digit_d;
  logic               last_q, last_d;
  logic [FRAC_W-1:0]  frac_q, frac_d;

  unpack_t unp;
  step_t   step;

  dtdf_unpack u_unpack (
    .raw_bits_i (raw_bits_i),
    .unp_o      (unp)
  );

  dtdf_step u_step (
    .frac_i (frac_q),
    .step_o (step)
  );

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    sign_d  = sign_q;
    ipart_d = ipart_q;
    digit_d = digit_q;
    last_d  = last_q;
    frac_d  = frac_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_OUT;
          sign_d  = unp.sign;
          digit_d = '0;
          if (unp.in_range) begin
            kind_d  = KIND_INT;
            ipart_d = unp.ipart;
            frac_d  = unp.frac;
            last_d  = (unp.frac == '0);
          end else begin
            kind_d  = KIND_RANGE;
            ipart_d = '0;
            frac_d  = '0;
            last_d  = 1'b1;
          end
        end
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          if (last_q) begin
            state_d = ST_IDLE;
          end else begin
            kind_d  = KIND_DIGIT;
            ipart_d = '0;
            digit_d = step.digit;
            frac_d  = step.frac;
            last_d  = (step.frac == '0);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    sign_q  <= sign_d;
    ipart_q <= ipart_d;
    digit_q <= digit_d;
    last_q  <= last_d;
    frac_q  <= frac_d;
  end

  assign in_stall_o      = (state_q != ST_IDLE);
  assign out_valid_o     = (state_q == ST_OUT);
  assign item_kind_o     = kind_q;
  assign sign_bit_o      = sign_q;
  assign integer_part_o  = ipart_q;
  assign decimal_digit_o = digit_q;
  assign last_item_o     = last_q;

endmodule

// ----- hdl/dtdf_checker.sv -----
module dtdf_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic [dtdf_pkg::WORD_W-1:0]  raw_bits_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [1:0]                   item_kind_o,
  input logic                         sign_bit_o,
  input logic [dtdf_pkg::IPART_W-1:0] integer_part_o,
  input logic [dtdf_pkg::DIGIT_W-1:0] decimal_digit_o,
  input logic                         last_item_o
);
  import dtdf_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(item_kind_o)
      && $stable(integer_part_o) && $stable(decimal_digit_o) && $stable(last_item_o))
    else $error("stalled output word changed");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o && out_valid_o)
    else $error("accepted word produced no output");

  a_no_accept_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while output pending");

  a_range_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && item_kind_o == KIND_RANGE |-> last_item_o && integer_part_o == '0)
    else $error("out-of-range word malformed");

  a_sign_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_item_o |=> out_valid_o
      && item_kind_o == KIND_DIGIT && $stable(sign_bit_o))
    else $error("digit word missing or sign changed");

endmodule

bind double_to_decimal_fraction_digits_unit dtdf_checker u_chk (.*);

// ----- dv/tb.sv -----
module tb;
  import dtdf_pkg::*;

  typedef struct packed {
    kind_e              kind;
    logic               sign;
    logic [IPART_W-1:0] ipart;
    logic [DIGIT_W-1:0] digit;
    logic               last;
  } expansion_word_t;

  localparam int unsigned RANDOM_WORDS = 450;
  localparam int unsigned MAX_WAIT     = 15;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned HOLD_AFTER   = 150;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                in_valid_i      = 1'b0;
  logic                in_stall_o;
  logic [WORD_W-1:0]   raw_bits_i      = '0;
  logic                out_valid_o;
  logic                out_stall_i     = 1'b0;
  logic [1:0]          item_kind_o;
  logic                sign_bit_o;
  logic [IPART_W-1:0]  integer_part_o;
  logic [DIGIT_W-1:0]  decimal_digit_o;
  logic                last_item_o;

  logic [WORD_W-1:0]   pending_words[$];
  expansion_word_t     expected_digits[$];

  int unsigned words_sent;
  int unsigned words_in_range;
  int unsigned words_out_of_range;
  int unsigned digits_checked;
  int unsigned longest_expansion;
  int unsigned mismatches;
  int unsigned send_gap;
  int unsigned stall_left;
  bit          tx_calm;
  bit          rx_calm;
  logic        stall_hold = 1'b0;

  double_to_decimal_fraction_digits_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .raw_bits_i      (raw_bits_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .item_kind_o     (item_kind_o),
    .sign_bit_o      (sign_bit_o),
    .integer_part_o  (integer_part_o),
    .decimal_digit_o (decimal_digit_o),
    .last_item_o     (last_item_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned pick_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic void expand_binary64(input logic [WORD_W-1:0] word);
    logic [EXP_W-1:0]   bexp;
    logic [IPART_W-1:0] mant;
    logic [PROD_W-1:0]  remainder;
    logic [PROD_W-1:0]  frac_mask;
    int unsigned        nfrac;
    int unsigned        produced;
    expansion_word_t    w;
    bexp = word[WORD_W-2:MANT_W];
    mant = {1'b1, word[MANT_W-1:0]};
    if (bexp < EXP_BIAS || bexp > EXP_MAX) begin
      w.kind  = KIND_RANGE;
      w.sign  = word[WORD_W-1];
      w.ipart = '0;
      w.digit = '0;
      w.last  = 1'b1;
      expected_digits.push_back(w);
      words_out_of_range++;
      return;
    end
    words_in_range++;
    nfrac     = MANT_W - int'(bexp - EXP_BIAS);
    frac_mask = (PROD_W'(1) << nfrac) - PROD_W'(1);
    remainder = PROD_W'(mant) & frac_mask;
    w.kind  = KIND_INT;
    w.sign  = word[WORD_W-1];
    w.ipart = mant >> nfrac;
    w.digit = '0;
    w.last  = (remainder == '0);
    expected_digits.push_back(w);
    produced = 1;
    while (remainder != '0 && produced < 53) begin
      remainder = remainder * PROD_W'(10);
      w.kind    = KIND_DIGIT;
      w.ipart   = '0;
      w.digit   = DIGIT_W'(remainder >> nfrac);
      remainder = remainder & frac_mask;
      w.last    = (remainder == '0);
      expected_digits.push_back(w);
      produced++;
    end
    if (produced > longest_expansion) longest_expansion = produced;
  endfunction

  function automatic logic [WORD_W-1:0] random_word();
    logic [WORD_W-1:0] word;
    int unsigned       pick;
    int unsigned       keep;
    pick = $urandom_range(0, 9);
    word = {$urandom, $urandom};
    if (pick == 0) return word;
    word[WORD_W-2:MANT_W] = EXP_BIAS + EXP_W'($urandom_range(0, MANT_W));
    if (pick == 1) begin
      keep = $urandom_range(1, 8);
      word[MANT_W-1:0] = word[MANT_W-1:0] & ~((MANT_W'(1) << (MANT_W - keep)) - MANT_W'(1));
    end
    return word;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      raw_bits_i <= '0;
      send_gap = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expand_binary64(raw_bits_i);
        words_sent++;
        if ($urandom_range(0, 19) == 0) tx_calm = !tx_calm;
        send_gap = pick_wait(tx_calm);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap == 0 && pending_words.size() != 0) begin
          in_valid_i <= 1'b1;
          raw_bits_i <= pending_words.pop_front();
        end else begin
          in_valid_i <= 1'b0;
          if (send_gap != 0) send_gap--;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    expansion_word_t want;
    expansion_word_t got;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        got = {kind_e'(item_kind_o), sign_bit_o, integer_part_o, decimal_digit_o,
               last_item_o};
        if (expected_digits.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: kind %0d sign %0d ipart %0d digit %0d last %0d",
                     got.kind, got.sign, got.ipart, got.digit, got.last);
        end else begin
          want = expected_digits.pop_front();
          digits_checked++;
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: expected kind %0d sign %0d ipart %0d digit %0d last %0d",
                       want.kind, want.sign, want.ipart, want.digit, want.last);
              $display("          got      kind %0d sign %0d ipart %0d digit %0d last %0d",
                       got.kind, got.sign, got.ipart, got.digit, got.last);
            end
          end
        end
        if ($urandom_range(0, 19) == 0) rx_calm = !rx_calm;
        stall_left = pick_wait(rx_calm);
      end else if (stall_left != 0) begin
        stall_left--;
      end
      out_stall_i <= stall_hold || stall_left != 0;
    end
  end

  initial begin
    wait (words_sent >= HOLD_AFTER);
    @(posedge clk_i);
    stall_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    stall_hold <= 1'b0;
  end

  initial begin
    #25_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    pending_words = '{
      64'h0000000000000000, 64'h8000000000000000, 64'h000FFFFFFFFFFFFF,
      64'h3FE0000000000000, 64'h3FB999999999999A, 64'h3FF0000000000000,
      64'hBFF0000000000000, 64'h3FF8000000000000, 64'h3FFFFFFFFFFFFFFF,
      64'h3FF0000000000001, 64'h432FFFFFFFFFFFFF, 64'h4330000000000000,
      64'hC33FFFFFFFFFFFFF, 64'h4340000000000000, 64'h7FF0000000000000,
      64'hFFF0000000000000, 64'h7FF8000000000001, 64'hFFFFFFFFFFFFFFFF,
      64'h7FEFFFFFFFFFFFFF, 64'h400921FB54442D18, 64'hC024000000000000
    };
    for (int i = 0; i < RANDOM_WORDS; i++) pending_words.push_back(random_word());
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    while (pending_words.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_digits.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("sent %0d words (%0d in range, %0d out of range), checked %0d result words",
             words_sent, words_in_range, words_out_of_range, digits_checked);
    $display("longest expansion %0d words, %0d mismatches", longest_expansion, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- double_to_decimal_fraction_digits_unit.f -----
hdl/dtdf_pkg.sv
hdl/dtdf_unpack.sv
hdl/dtdf_step.sv
hdl/double_to_decimal_fraction_digits_unit.sv
hdl/dtdf_checker.sv
dv/tb.sv
